// ----- hdl/utf8_russian_token_filter_unit_assert.svh -----
// Assertion macros for the token filter. Each use checks on the rising edge
// of clk and is held off while arst_n is low.
`ifndef UTF8_RUSSIAN_TOKEN_FILTER_UNIT_ASSERT_SVH
`define UTF8_RUSSIAN_TOKEN_FILTER_UNIT_ASSERT_SVH

// Same-cycle implication.
`define RUTF_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define RUTF_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- hdl/rutf_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rutf_pkg
// Shared types and constants of the UTF-8 Russian token filter.
// ----------------------------------------------------------------------------
package rutf_pkg;

	localparam int TOKEN_BYTES_DEF = 64;
	localparam int LEN_W = 7;
	localparam int CHR_W = 6;
	localparam int LET_W = 5;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 20;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_TEXT = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_WORD = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_NUM  = 2'd2;

	localparam logic [19:0] MAX_TEXT_RST = 20'd100000;
	localparam logic [4:0]  MAX_WORD_RST = 5'd20;
	localparam logic [3:0]  MAX_NUM_RST  = 4'd4;

	localparam logic [7:0] LEAD_D0    = 8'hD0;
	localparam logic [7:0] LEAD_D1    = 8'hD1;
	localparam logic [7:0] HYPHEN     = 8'h2D;
	localparam logic [7:0] ASCII_ZERO = 8'h30;

	localparam logic KIND_NUMBER = 1'b0;
	localparam logic KIND_WORD   = 1'b1;

	typedef struct packed {
		logic [LEN_W-1:0] len;
		logic [1:0]       phy;
		logic [CHR_W-1:0] chars;
		logic [LET_W-1:0] lbh;
		logic [LET_W-1:0] lah;
		logic             digits;
		logic             word;
		logic             hyph;
		logic             over;
		logic [15:0]      run_letter;
		logic [1:0]       run_cnt;
		logic             zero_first;
	} tok_t;

	typedef struct packed {
		logic             bank;
		logic [LEN_W-1:0] len;
		logic             kind;
	} cmd_t;

	typedef struct packed {
		logic             en;
		logic             bank;
		logic [LEN_W-1:0] pos;
		logic [7:0]       dat;
	} wr_t;

	typedef struct packed {
		logic             en;
		logic             bank;
		logic [LEN_W-1:0] pos;
	} rd_t;

	function automatic tok_t tok_clear();
		tok_t t;
		t = '0;
		t.digits = 1'b1;
		t.word = 1'b1;
		return t;
	endfunction

endpackage

// ----- hdl/rutf_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rutf_text_if / rutf_token_if
// Valid/ready channels for text bytes in and token bytes out.
// ----------------------------------------------------------------------------
interface rutf_text_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       end_of_text;
	modport source (output valid, data_byte, end_of_text, input ready);
	modport sink (input valid, data_byte, end_of_text, output ready);
endinterface

interface rutf_token_if;
	logic       valid;
	logic       ready;
	logic [7:0] token_byte;
	logic       token_last;
	logic       token_kind;
	modport source (output valid, token_byte, token_last, token_kind, input ready);
	modport sink (input valid, token_byte, token_last, token_kind, output ready);
endinterface

// ----- hdl/rutf_store.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rutf_store
// Token byte store: four interleaved banks, two token buffers each.
// ----------------------------------------------------------------------------
module rutf_store #(
	parameter int TOKEN_BYTES = rutf_pkg::TOKEN_BYTES_DEF
) (
	input  logic              clk,
	input  rutf_pkg::wr_t [2:0] wr,
	input  rutf_pkg::rd_t     rd,
	output logic [7:0]        rd_data
);
	localparam int DEP = (TOKEN_BYTES + 3) / 4;
	localparam int AW  = $clog2(DEP);

	logic [7:0] rd_q [4];
	logic [1:0] sel_q;

	for (genvar k = 0; k < 4; k++) begin : g_bank
		// The buffer select is the top address bit, so each buffer spans a
		// full power-of-two range.
		logic [7:0]  mem [2**(AW+1)];
		logic        we;
		logic [AW:0] wa;
		logic [7:0]  wd;

		always_comb begin
			we = 1'b0;
			wa = '0;
			wd = '0;
			for (int i = 0; i < 3; i++) begin
				if (wr[i].en && wr[i].pos[1:0] == 2'(k)) begin
					we = 1'b1;
					wa = {wr[i].bank, wr[i].pos[AW+1:2]};
					wd = wr[i].dat;
				end
			end
		end

		always_ff @(posedge clk) begin
			if (we) begin
				mem[wa] <= wd;
			end
			if (rd.en) begin
				rd_q[k] <= mem[{rd.bank, rd.pos[AW+1:2]}];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rd.en) begin
			sel_q <= rd.pos[1:0];
		end
	end

	assign rd_data = rd_q[sel_q];

endmodule

// ----- hdl/rutf_cmdq.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rutf_cmdq
// Two-entry queue of finished tokens waiting to be sent.
// ----------------------------------------------------------------------------
module rutf_cmdq (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic [1:0]           push_n,
	input  rutf_pkg::cmd_t [1:0] push_cmd,
	input  logic                 pop,
	output rutf_pkg::cmd_t       head,
	output logic                 not_empty
);
	rutf_pkg::cmd_t [1:0] ent_q;
	logic [1:0]           cnt_q;
	rutf_pkg::cmd_t [1:0] ent_d;
	logic [1:0]           cnt_d;

	// Pushes only arrive while the queue is empty, so at most two are held.
	always_comb begin
		ent_d = ent_q;
		cnt_d = cnt_q;
		if (pop) begin
			ent_d[0] = ent_q[1];
			cnt_d = cnt_q - 2'd1;
		end
		if (push_n != 2'd0) begin
			ent_d[cnt_d[0]] = push_cmd[0];
			if (push_n == 2'd2) begin
				ent_d[1] = push_cmd[1];
			end
		end
		cnt_d = cnt_d + push_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else begin
			cnt_q <= cnt_d;
		end
	end

	always_ff @(posedge clk) begin
		ent_q <= ent_d;
	end

	assign head = ent_q[0];
	assign not_empty = cnt_q != 2'd0;

endmodule

// ----- hdl/rutf_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rutf_front
// Accepts text bytes, classifies them and builds the current token.
// ----------------------------------------------------------------------------
module rutf_front #(
	parameter int TOKEN_BYTES = rutf_pkg::TOKEN_BYTES_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	rutf_text_if.sink                             text,
	input  logic                                  accept_ok,
	input  logic                                  cfg_we,
	input  logic [rutf_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [rutf_pkg::CFG_DATA_W-1:0]       cfg_data,
	output rutf_pkg::wr_t [2:0]                   wr,
	output logic [1:0]                            push_n,
	output rutf_pkg::cmd_t [1:0]                  push_cmd
);
	localparam logic [1:0] FIN_NUMBER = 2'd0;
	localparam logic [1:0] FIN_WORD   = 2'd1;
	localparam logic [1:0] FIN_NONE   = 2'd2;

	typedef struct packed {
		rutf_pkg::tok_t       tok;
		logic                 bank;
		logic [1:0]           n_emit;
		rutf_pkg::cmd_t [1:0] cmd;
		logic [1:0]           n_wr;
		rutf_pkg::wr_t [2:0]  w;
	} ctx_t;

	logic [19:0] max_text_q;
	logic [4:0]  max_word_q;
	logic [3:0]  max_num_q;

	rutf_pkg::tok_t tok_q;
	logic           bank_q;
	logic           pl_v_q;
	logic [7:0]     pl_b_q;
	logic [19:0]    seen_q;

	ctx_t        c;
	logic        pl_v_d;
	logic [7:0]  pl_b_d;
	logic [19:0] seen_d;
	logic        acc;

	function automatic ctx_t put_byte(ctx_t ci, logic [7:0] v);
		ctx_t co;
		co = ci;
		if (co.tok.len < rutf_pkg::LEN_W'(TOKEN_BYTES)) begin
			co.w[co.n_wr] = '{en: 1'b1, bank: co.bank, pos: co.tok.len, dat: v};
			if (co.tok.len == '0) begin
				co.tok.zero_first = (v == rutf_pkg::ASCII_ZERO);
			end
			co.n_wr = co.n_wr + 2'd1;
			co.tok.len = co.tok.len + 1'b1;
		end else begin
			co.tok.over = 1'b1;
		end
		return co;
	endfunction

	function automatic ctx_t bump(ctx_t ci);
		ctx_t co;
		co = ci;
		if (co.tok.chars != '1) begin
			co.tok.chars = co.tok.chars + 1'b1;
		end
		return co;
	endfunction

	// Two or more held hyphens always kill the token, so only a single one is stored.
	function automatic ctx_t place_hyphens(ctx_t ci);
		ctx_t co;
		co = ci;
		if (co.tok.phy == 2'd1) begin
			co = put_byte(co, rutf_pkg::HYPHEN);
			co = bump(co);
			co.tok.digits = 1'b0;
			if (co.tok.hyph) begin
				co.tok.word = 1'b0;
			end
			co.tok.hyph = 1'b1;
			co.tok.run_cnt = '0;
		end else if (co.tok.phy != 2'd0) begin
			co.tok.digits = 1'b0;
			co.tok.word = 1'b0;
			co.tok.hyph = 1'b1;
			co.tok.run_cnt = '0;
		end
		co.tok.phy = '0;
		return co;
	endfunction

	function automatic ctx_t add_ascii(ctx_t ci, logic [7:0] b);
		ctx_t       co;
		logic [7:0] v;
		co = place_hyphens(ci);
		v = b;
		if (b inside {[8'h41:8'h5A]}) begin
			v = b + 8'h20;
		end
		co = put_byte(co, v);
		co = bump(co);
		if (!(v inside {[8'h30:8'h39]})) begin
			co.tok.digits = 1'b0;
		end
		co.tok.word = 1'b0;
		co.tok.run_cnt = '0;
		return co;
	endfunction

	function automatic ctx_t add_pair(ctx_t ci, logic [7:0] lead, logic [7:0] cont);
		ctx_t        co;
		logic [7:0]  l;
		logic [7:0]  cn;
		logic        letter;
		logic [15:0] code;
		co = place_hyphens(ci);
		l = lead;
		cn = cont;
		if (l == rutf_pkg::LEAD_D0) begin
			if (cn inside {[8'h90:8'h9F]}) begin
				cn = cn + 8'h20;
			end else if (cn inside {[8'hA0:8'hAF]}) begin
				l = rutf_pkg::LEAD_D1;
				cn = cn - 8'h20;
			end else if (cn == 8'h81) begin
				l = rutf_pkg::LEAD_D1;
				cn = 8'h91;
			end
		end
		co = put_byte(co, l);
		co = put_byte(co, cn);
		co = bump(co);
		co.tok.digits = 1'b0;
		letter = (l == rutf_pkg::LEAD_D0 && cn inside {[8'hB0:8'hBF]}) ||
			(l == rutf_pkg::LEAD_D1 && cn inside {[8'h80:8'h9F]});
		code = {l, cn};
		if (!letter) begin
			co.tok.word = 1'b0;
			co.tok.run_cnt = '0;
		end else begin
			if (co.tok.run_cnt != 2'd0 && code == co.tok.run_letter) begin
				if (co.tok.run_cnt != 2'd3) begin
					co.tok.run_cnt = co.tok.run_cnt + 2'd1;
				end
				if (co.tok.run_cnt == 2'd3) begin
					co.tok.word = 1'b0;
				end
			end else begin
				co.tok.run_letter = code;
				co.tok.run_cnt = 2'd1;
			end
			if (co.tok.hyph) begin
				if (co.tok.lah != '1) begin
					co.tok.lah = co.tok.lah + 1'b1;
				end
			end else if (co.tok.lbh != '1) begin
				co.tok.lbh = co.tok.lbh + 1'b1;
			end
		end
		return co;
	endfunction

	function automatic logic [1:0] fin_kind(rutf_pkg::tok_t t, logic [4:0] mw, logic [3:0] mn);
		logic       ok;
		logic [1:0] k;
		ok = t.len != '0 && !t.over;
		k = FIN_NONE;
		if (ok && t.digits) begin
			if (t.len == rutf_pkg::LEN_W'(1) && t.zero_first) begin
				k = FIN_NUMBER;
			end else if (!(t.len > rutf_pkg::LEN_W'(1) && t.zero_first) &&
				t.len <= rutf_pkg::LEN_W'(mn)) begin
				k = FIN_NUMBER;
			end
		end
		if (k == FIN_NONE && ok && t.word && t.lbh != '0 &&
			t.chars <= rutf_pkg::CHR_W'(mw) &&
			(!t.hyph || (t.lbh >= 5'd2 && t.lah >= 5'd2))) begin
			k = FIN_WORD;
		end
		return k;
	endfunction

	// A finished token that is kept goes to the queue and the next token opens the other buffer.
	function automatic ctx_t finish(ctx_t ci, logic [4:0] mw, logic [3:0] mn);
		ctx_t       co;
		logic [1:0] k;
		co = ci;
		k = fin_kind(co.tok, mw, mn);
		if (k != FIN_NONE) begin
			co.cmd[co.n_emit[0]] = '{bank: co.bank, len: co.tok.len, kind: k[0]};
			co.n_emit = co.n_emit + 2'd1;
			co.bank = ~co.bank;
		end
		co.tok = rutf_pkg::tok_clear();
		return co;
	endfunction

	assign text.ready = accept_ok;
	assign acc = text.valid && accept_ok;

	always_comb begin
		logic [7:0] b;
		logic       eot;
		logic       last;
		logic       fresh;
		c = '0;
		c.tok = tok_q;
		c.bank = bank_q;
		pl_v_d = pl_v_q;
		pl_b_d = pl_b_q;
		seen_d = seen_q;
		b = text.data_byte;
		eot = text.end_of_text;
		last = 1'b0;
		fresh = 1'b1;
		if (acc) begin
			if (seen_q < max_text_q) begin
				last = eot || (seen_q + 20'd1 == max_text_q);
				seen_d = seen_q + 20'd1;
				if (pl_v_q) begin
					pl_v_d = 1'b0;
					if (b inside {[8'h80:8'hBF]}) begin
						c = add_pair(c, pl_b_q, b);
						fresh = 1'b0;
					end else begin
						c = finish(c, max_word_q, max_num_q);
					end
				end
				if (fresh) begin
					if (b == rutf_pkg::LEAD_D0 || b == rutf_pkg::LEAD_D1) begin
						if (last) begin
							c = finish(c, max_word_q, max_num_q);
						end else begin
							pl_v_d = 1'b1;
							pl_b_d = b;
						end
					end else if (b == rutf_pkg::HYPHEN) begin
						if (c.tok.len != '0 && c.tok.phy != 2'd3) begin
							c.tok.phy = c.tok.phy + 2'd1;
						end
					end else if (b inside {[8'h30:8'h39], [8'h41:8'h5A], [8'h61:8'h7A]}) begin
						c = add_ascii(c, b);
					end else begin
						c = finish(c, max_word_q, max_num_q);
					end
				end
				if (last) begin
					pl_v_d = 1'b0;
					c = finish(c, max_word_q, max_num_q);
				end
			end
			if (eot) begin
				pl_v_d = 1'b0;
				c = finish(c, max_word_q, max_num_q);
				seen_d = '0;
			end
		end
	end

	assign wr = acc ? c.w : '0;
	assign push_n = acc ? c.n_emit : 2'd0;
	assign push_cmd = c.cmd;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_text_q <= rutf_pkg::MAX_TEXT_RST;
			max_word_q <= rutf_pkg::MAX_WORD_RST;
			max_num_q <= rutf_pkg::MAX_NUM_RST;
			tok_q <= rutf_pkg::tok_clear();
			bank_q <= 1'b0;
			pl_v_q <= 1'b0;
			pl_b_q <= '0;
			seen_q <= '0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					rutf_pkg::CFG_MAX_TEXT: max_text_q <= cfg_data;
					rutf_pkg::CFG_MAX_WORD: max_word_q <= cfg_data[4:0];
					rutf_pkg::CFG_MAX_NUM: max_num_q <= cfg_data[3:0];
					default: ;
				endcase
			end
			if (acc) begin
				tok_q <= c.tok;
				bank_q <= c.bank;
				pl_v_q <= pl_v_d;
				pl_b_q <= pl_b_d;
				seen_q <= seen_d;
			end
		end
	end

endmodule

// ----- hdl/rutf_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rutf_back
// Reads finished tokens out of the store and sends them one word at a time.
// ----------------------------------------------------------------------------
module rutf_back (
	input  logic           clk,
	input  logic           arst_n,
	input  rutf_pkg::cmd_t head,
	input  logic           not_empty,
	output logic           pop,
	output logic           busy,
	output rutf_pkg::rd_t  rd,
	input  logic [7:0]     rd_data,
	rutf_token_if.source   token
);
	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_READ = 2'd1;
	localparam logic [1:0] ST_SHOW = 2'd2;

	logic [1:0]                 st_q;
	logic                       bank_q;
	logic [rutf_pkg::LEN_W-1:0] len_q;
	logic                       kind_q;
	logic [rutf_pkg::LEN_W-1:0] idx_q;
	logic                       last;

	assign last = (idx_q + 1'b1 == len_q);
	assign pop = (st_q == ST_IDLE) && not_empty;
	assign busy = st_q != ST_IDLE;
	assign rd = '{en: st_q == ST_READ, bank: bank_q, pos: idx_q};

	assign token.valid = st_q == ST_SHOW;
	assign token.token_byte = rd_data;
	assign token.token_last = last;
	assign token.token_kind = kind_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
			idx_q <= '0;
		end else begin
			case (st_q)
				ST_IDLE: begin
					if (not_empty) begin
						idx_q <= '0;
						st_q <= ST_READ;
					end
				end
				ST_READ: st_q <= ST_SHOW;
				ST_SHOW: begin
					if (token.ready) begin
						if (last) begin
							st_q <= ST_IDLE;
						end else begin
							idx_q <= idx_q + 1'b1;
							st_q <= ST_READ;
						end
					end
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			bank_q <= head.bank;
			len_q <= head.len;
			kind_q <= head.kind;
		end
	end

endmodule

// ----- hdl/utf8_russian_token_filter_unit.sv -----
`timescale 1ns / 1ps
// A token that ends with an accepted byte is pushed into the queue, popped by the back
// end, read from the store and then offered as its first word.
// Throughput: one text byte per cycle while nothing is being sent; each word of an accepted
// token is read from the store, then handed off, through the single store read port.
// The text side stalls from a token's finish until its last word has been taken.
// Reset: arst_n clears all control state and loads the register defaults; no clearing pass.
// ----------------------------------------------------------------------------
// utf8_russian_token_filter_unit
// Splits UTF-8 text into tokens and passes on numbers and Russian words.
// ----------------------------------------------------------------------------
`include "utf8_russian_token_filter_unit_assert.svh"

module utf8_russian_token_filter_unit #(
	parameter int TOKEN_BYTES = rutf_pkg::TOKEN_BYTES_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	rutf_text_if.sink                         text,
	rutf_token_if.source                      token,
	input  logic                              cfg_we,
	input  logic [rutf_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [rutf_pkg::CFG_DATA_W-1:0]   cfg_data
);
	// The front end classifies each byte combinationally and writes up to three
	// bytes (a held hyphen and a two-byte letter) into the store, which is split
	// into four banks by the low position bits so all three land at once.
	// Each bank holds two token buffers: when a token is finished the next one
	// opens in the other buffer, since a single byte can both end one token and
	// start another, and end_of_text can then finish that second one too.
	// Finished tokens wait in a two-entry queue for the back end.

	rutf_pkg::wr_t [2:0]  wr;
	rutf_pkg::rd_t        rd;
	logic [7:0]           rd_data;
	logic [1:0]           push_n;
	rutf_pkg::cmd_t [1:0] push_cmd;
	rutf_pkg::cmd_t       head;
	logic                 not_empty;
	logic                 pop;
	logic                 busy;
	logic                 accept_ok;

	// Text is taken only when every earlier token has gone out, so both
	// buffers are free for whatever the next byte finishes.
	assign accept_ok = !not_empty && !busy;

	rutf_front #(.TOKEN_BYTES(TOKEN_BYTES)) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.text      (text),
		.accept_ok (accept_ok),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.wr        (wr),
		.push_n    (push_n),
		.push_cmd  (push_cmd)
	);

	rutf_store #(.TOKEN_BYTES(TOKEN_BYTES)) u_store (
		.clk     (clk),
		.wr      (wr),
		.rd      (rd),
		.rd_data (rd_data)
	);

	rutf_cmdq u_cmdq (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_n    (push_n),
		.push_cmd  (push_cmd),
		.pop       (pop),
		.head      (head),
		.not_empty (not_empty)
	);

	rutf_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.not_empty (not_empty),
		.pop       (pop),
		.busy      (busy),
		.rd        (rd),
		.rd_data   (rd_data),
		.token     (token)
	);

	// While a word is shown, no text byte may be taken.
	`RUTF_ASSERT_IMP(a_no_text_while_sending, token.valid, !text.ready, "text taken while sending")
	// A byte just taken cannot already show a word on the next cycle.
	`RUTF_ASSERT_NXT(a_gap_after_text, text.valid && text.ready, !token.valid, "word too early")

endmodule

// ----- sim/utf8_russian_token_filter_unit_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8_russian_token_filter_unit_tb
// Feeds UTF-8 text bytes into the token filter and checks every token word
// against a cycle-free model of the filter, kept in step with each accepted
// text byte. A short directed table comes first, then random text phases
// under several register settings, with random stalls on both channels in all but the last.
// ----------------------------------------------------------------------------
module utf8_russian_token_filter_unit_tb;

	typedef struct packed {
		logic [7:0] tbyte;
		logic       last;
		logic       kind;
	} token_word_t;

	// One row of the directed table: a text byte, its end-of-text mark and
	// the number of token words it must release (-1 where only the model
	// decides).
	typedef struct {
		logic [7:0] dbyte;
		logic       eot;
		int         n_words;
	} text_row_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [rutf_pkg::CFG_IDX_W-1:0] cfg_index;
	logic [rutf_pkg::CFG_DATA_W-1:0] cfg_data;

	rutf_text_if  text_ch();
	rutf_token_if token_ch();

	utf8_russian_token_filter_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.text(text_ch),
		.token(token_ch),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	// Expected token words, oldest first.
	token_word_t pending_words[$];
	int errors;
	int words_made;
	bit calm;

	// Register copies.
	int lim_text, lim_word, lim_num;

	// Token model state.
	logic [7:0] tok_mem[rutf_pkg::TOKEN_BYTES_DEF];
	int tok_len, hy_pend, n_chars, lbh, lah, run_n, seen;
	bit f_dig, f_word, f_hyph, f_over, lead_ok;
	logic [7:0] lead_b;
	logic [15:0] run_ltr;

	// Text bytes still to be sent; bit 8 marks end of text.
	logic [8:0] stream[$];
	logic [15:0] last_letter;

	task automatic queue_text(input logic [8:0] w);
		stream.insert(stream.size(), w);
	endtask

	task automatic expect_word(input token_word_t w);
		pending_words.insert(pending_words.size(), w);
	endtask

	task automatic clear_token();
		tok_len = 0; hy_pend = 0; n_chars = 0; lbh = 0; lah = 0;
		f_dig = 1; f_word = 1; f_hyph = 0; f_over = 0;
		run_ltr = '0; run_n = 0;
	endtask

	task automatic store_byte(input logic [7:0] v);
		if (tok_len < rutf_pkg::TOKEN_BYTES_DEF) begin
			tok_mem[tok_len] = v;
			tok_len++;
		end else begin
			f_over = 1;
		end
	endtask

	task automatic count_char();
		if (n_chars < 63)
			n_chars++;
	endtask

	// Hyphens are held back until a character follows them, so trailing
	// hyphens never reach the token.
	task automatic place_hyphens();
		while (hy_pend > 0) begin
			store_byte(rutf_pkg::HYPHEN);
			count_char();
			f_dig = 0;
			if (f_hyph)
				f_word = 0;
			f_hyph = 1;
			run_n = 0;
			hy_pend--;
		end
	endtask

	task automatic add_ascii(input logic [7:0] c);
		place_hyphens();
		if (c >= "A" && c <= "Z")
			c = c + 8'h20;
		store_byte(c);
		count_char();
		if (c < "0" || c > "9")
			f_dig = 0;
		f_word = 0;
		run_n = 0;
	endtask

	task automatic add_pair(input logic [7:0] lead, input logic [7:0] cont);
		place_hyphens();
		// Capitals fold to lowercase, the capital yo included.
		if (lead == rutf_pkg::LEAD_D0) begin
			if (cont >= 8'h90 && cont <= 8'h9F) begin
				cont = cont + 8'h20;
			end else if (cont >= 8'hA0 && cont <= 8'hAF) begin
				lead = rutf_pkg::LEAD_D1;
				cont = cont - 8'h20;
			end else if (cont == 8'h81) begin
				lead = rutf_pkg::LEAD_D1;
				cont = 8'h91;
			end
		end
		store_byte(lead);
		store_byte(cont);
		count_char();
		f_dig = 0;
		if (!((lead == rutf_pkg::LEAD_D0 && cont >= 8'hB0) ||
		      (lead == rutf_pkg::LEAD_D1 && cont <= 8'h9F))) begin
			f_word = 0;
			run_n = 0;
			return;
		end
		if (run_n > 0 && {lead, cont} == run_ltr) begin
			if (run_n < 3)
				run_n++;
			if (run_n >= 3)
				f_word = 0;
		end else begin
			run_ltr = {lead, cont};
			run_n = 1;
		end
		if (f_hyph) begin
			if (lah < 31)
				lah++;
		end else if (lbh < 31) begin
			lbh++;
		end
	endtask

	// Classifies the open token, queues its words if it is kept, and clears it.
	task automatic close_token();
		bit ok, keep;
		logic kind;
		token_word_t w;
		ok = tok_len > 0 && !f_over;
		keep = 0;
		kind = rutf_pkg::KIND_NUMBER;
		if (ok && f_dig) begin
			if (tok_len == 1 && tok_mem[0] == rutf_pkg::ASCII_ZERO)
				keep = 1;
			else if (!(tok_len > 1 && tok_mem[0] == rutf_pkg::ASCII_ZERO) &&
			         tok_len <= lim_num)
				keep = 1;
		end
		if (!keep && ok && f_word && lbh > 0 && n_chars <= lim_word &&
		    (!f_hyph || (lbh >= 2 && lah >= 2))) begin
			keep = 1;
			kind = rutf_pkg::KIND_WORD;
		end
		if (keep) begin
			for (int i = 0; i < tok_len; i++) begin
				w.tbyte = tok_mem[i];
				w.last = (i + 1 == tok_len);
				w.kind = kind;
				expect_word(w);
				words_made++;
			end
		end
		clear_token();
	endtask

	task automatic predict_byte(input logic [7:0] b, input logic eot);
		bit last, fresh;
		logic [7:0] lead;
		if (seen < lim_text) begin
			last = eot || seen + 1 == lim_text;
			fresh = 1;
			seen++;
			if (lead_ok) begin
				lead = lead_b;
				lead_ok = 0;
				if (b >= 8'h80 && b <= 8'hBF) begin
					add_pair(lead, b);
					fresh = 0;
				end else begin
					close_token();
				end
			end
			if (fresh) begin
				if (b == rutf_pkg::LEAD_D0 || b == rutf_pkg::LEAD_D1) begin
					if (last) begin
						close_token();
					end else begin
						lead_ok = 1;
						lead_b = b;
					end
				end else if (b == rutf_pkg::HYPHEN) begin
					if (tok_len > 0 && hy_pend < 3)
						hy_pend++;
				end else if ((b >= "0" && b <= "9") || (b >= "A" && b <= "Z") ||
				             (b >= "a" && b <= "z")) begin
					add_ascii(b);
				end else begin
					close_token();
				end
			end
			if (last) begin
				lead_ok = 0;
				close_token();
			end
		end
		if (eot) begin
			lead_ok = 0;
			close_token();
			seen = 0;
		end
	endtask

	// Clock.
	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	// Hard limit on the run.
	initial begin
		#10ms;
		$display("Some tests failed");
		$finish;
	end

	// Token side: checks each accepted word, then decides on ready for the
	// next edge. Stalls start at random and come in bursts.
	initial begin
		int stall_left;
		token_word_t exp_w;
		stall_left = 0;
		token_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && token_ch.valid && token_ch.ready) begin
				if (pending_words.size() == 0) begin
					$error("unexpected token word %h", token_ch.token_byte);
					errors++;
				end else begin
					exp_w = pending_words.pop_front();
					if (token_ch.token_byte !== exp_w.tbyte) begin
						$error("token_byte: expected %h, got %h", exp_w.tbyte,
						       token_ch.token_byte);
						errors++;
					end
					if (token_ch.token_last !== exp_w.last) begin
						$error("token_last: expected %b, got %b", exp_w.last,
						       token_ch.token_last);
						errors++;
					end
					if (token_ch.token_kind !== exp_w.kind) begin
						$error("token_kind: expected %b, got %b", exp_w.kind,
						       token_ch.token_kind);
						errors++;
					end
				end
			end
			if (stall_left > 0) begin
				stall_left--;
				token_ch.ready <= 1'b0;
			end else if (!calm && $urandom_range(0, 4) == 0) begin
				stall_left = $urandom_range(1, 3) - 1;
				token_ch.ready <= 1'b0;
			end else begin
				token_ch.ready <= 1'b1;
			end
		end
	end

	// Offers one text word and waits for the handshake; valid stays high so a
	// following word can go out back to back.
	task automatic send_byte(input logic [7:0] b, input logic eot);
		text_ch.valid <= 1'b1;
		text_ch.data_byte <= b;
		text_ch.end_of_text <= eot;
		do
			@(posedge clk);
		while (!text_ch.ready);
		predict_byte(b, eot);
	endtask

	task automatic maybe_idle();
		if (!calm && $urandom_range(0, 5) == 0) begin
			text_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
	endtask

	// Waits until every expected word has come, then keeps idling so that a
	// token that releases nothing has also settled inside the block.
	task automatic drain();
		text_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending_words.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_reg(input logic [rutf_pkg::CFG_IDX_W-1:0] idx, input int val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val[rutf_pkg::CFG_DATA_W-1:0];
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			rutf_pkg::CFG_MAX_TEXT: lim_text = val;
			rutf_pkg::CFG_MAX_WORD: lim_word = val;
			rutf_pkg::CFG_MAX_NUM:  lim_num = val;
			default: ;
		endcase
	endtask

	task automatic push_letter();
		logic [7:0] lead, cont;
		if (last_letter != 0 && $urandom_range(0, 4) == 0) begin
			lead = last_letter[15:8];
			cont = last_letter[7:0];
		end else begin
			case ($urandom_range(0, 3))
				0: begin
					lead = rutf_pkg::LEAD_D0;
					cont = 8'($urandom_range(8'h90, 8'hAF));
				end
				1: begin
					lead = rutf_pkg::LEAD_D0;
					cont = 8'($urandom_range(8'hB0, 8'hBF));
				end
				2: begin
					lead = rutf_pkg::LEAD_D1;
					cont = 8'($urandom_range(8'h80, 8'h8F));
				end
				default: begin
					lead = $urandom_range(0, 1) ? rutf_pkg::LEAD_D0 : rutf_pkg::LEAD_D1;
					cont = (lead == rutf_pkg::LEAD_D0) ? 8'h81 : 8'h91;
				end
			endcase
		end
		last_letter = {lead, cont};
		queue_text({1'b0, lead});
		queue_text({1'b0, cont});
	endtask

	// Builds one random token with a separator behind it. Most tokens are
	// well formed numbers and words; the rest is Latin, noise and broken
	// lead bytes.
	task automatic make_token();
		int n, hp;
		logic [7:0] sep;
		last_letter = '0;
		case ($urandom_range(0, 9))
			0, 1: begin
				n = $urandom_range(1, 9);
				for (int i = 0; i < n; i++)
					queue_text({1'b0, 8'(8'h30 + $urandom_range(0, 9))});
			end
			2, 3, 4, 5, 6: begin
				n = ($urandom_range(0, 11) == 0) ? $urandom_range(30, 40) :
				    $urandom_range(1, 10);
				hp = ($urandom_range(0, 2) == 0 && n > 1) ? $urandom_range(1, n - 1) : 0;
				if ($urandom_range(0, 7) == 0)
					queue_text({1'b0, rutf_pkg::HYPHEN});
				for (int i = 0; i < n; i++) begin
					if (i == hp && hp != 0) begin
						queue_text({1'b0, rutf_pkg::HYPHEN});
						if ($urandom_range(0, 5) == 0)
							queue_text({1'b0, rutf_pkg::HYPHEN});
					end
					push_letter();
				end
				if ($urandom_range(0, 7) == 0)
					queue_text({1'b0, rutf_pkg::HYPHEN});
			end
			7: begin
				n = $urandom_range(1, 6);
				for (int i = 0; i < n; i++)
					case ($urandom_range(0, 2))
						0: queue_text({1'b0, 8'($urandom_range(8'h41, 8'h5A))});
						1: queue_text({1'b0, 8'($urandom_range(8'h61, 8'h7A))});
						default: push_letter();
					endcase
			end
			8: queue_text({1'b0, 8'($urandom_range(0, 255))});
			default: begin
				push_letter();
				queue_text({1'b0, $urandom_range(0, 1) ? rutf_pkg::LEAD_D0 : rutf_pkg::LEAD_D1});
				queue_text({1'b0, 8'($urandom_range(0, 255))});
			end
		endcase
		case ($urandom_range(0, 3))
			0: sep = " ";
			1: sep = ",";
			2: sep = 8'h0A;
			default: sep = 8'($urandom_range(0, 255));
		endcase
		queue_text({$urandom_range(0, 9) == 0 ? 1'b1 : 1'b0, sep});
	endtask

	// Sends about n_items random text words; with hold_mid set the sender
	// stops halfway until every expected word has arrived.
	task automatic run_phase(input int n_items, input bit hold_mid);
		int sent;
		logic [8:0] w;
		bit held;
		sent = 0;
		held = 0;
		while (sent < n_items) begin
			make_token();
			while (stream.size() != 0) begin
				w = stream.pop_front();
				maybe_idle();
				send_byte(w[7:0], w[8]);
				sent++;
			end
			if (hold_mid && !held && sent >= n_items / 2) begin
				held = 1;
				text_ch.valid <= 1'b0;
				@(posedge clk);
				while (pending_words.size() != 0)
					@(posedge clk);
			end
		end
		drain();
	endtask

	text_row_t dir_rows[25] = '{
		'{"0", 0, 0}, '{" ", 0, 1},          // lone zero is a number
		'{"Z", 0, 0}, '{8'hFF, 0, 0},        // Latin token is dropped
		'{"-", 0, 0},                        // leading hyphen
		'{8'hD0, 0, 0}, '{8'h81, 0, 0},      // capital yo
		'{8'hD0, 0, 0}, '{8'h96, 0, 0},
		'{"-", 0, 0},
		'{8'hD1, 0, 0}, '{8'h8F, 0, 0},
		'{8'hD0, 0, 0}, '{8'hB0, 0, 0},
		'{"-", 0, 0}, '{",", 0, 9},          // trailing hyphen dropped
		'{"7", 0, 0}, '{8'hD0, 0, 0}, '{"a", 0, 1}, // lead without follower
		'{"1", 0, 0}, '{"2", 0, 0}, '{"3", 0, 0}, '{"4", 0, 0},
		'{"5", 0, 0}, '{8'hD1, 1, 0}         // mixed token, lead at end of text
	};

	initial begin
		int before_cnt;
		errors = 0;
		words_made = 0;
		calm = 0;
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= rutf_pkg::CFG_MAX_TEXT;
		cfg_data <= '0;
		text_ch.valid <= 1'b0;
		text_ch.data_byte <= '0;
		text_ch.end_of_text <= 1'b0;
		lim_text = rutf_pkg::MAX_TEXT_RST;
		lim_word = rutf_pkg::MAX_WORD_RST;
		lim_num = rutf_pkg::MAX_NUM_RST;
		seen = 0;
		lead_ok = 0;
		lead_b = '0;
		clear_token();
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed table under the reset settings.
		foreach (dir_rows[i]) begin
			before_cnt = words_made;
			maybe_idle();
			send_byte(dir_rows[i].dbyte, dir_rows[i].eot);
			if (dir_rows[i].n_words >= 0 && words_made - before_cnt != dir_rows[i].n_words) begin
				$error("word count of row %0d: expected %0d, got %0d", i,
				       dir_rows[i].n_words, words_made - before_cnt);
				errors++;
			end
		end
		drain();

		run_phase(70, 1);

		// Widest text and word limits, with a number limit of eight.
		write_reg(rutf_pkg::CFG_MAX_TEXT, 1048575);
		write_reg(rutf_pkg::CFG_MAX_WORD, 31);
		write_reg(rutf_pkg::CFG_MAX_NUM, 8);
		run_phase(60, 0);

		// Word and number limits of one, with a short text limit that cuts tokens off.
		write_reg(rutf_pkg::CFG_MAX_TEXT, 40);
		write_reg(rutf_pkg::CFG_MAX_WORD, 1);
		write_reg(rutf_pkg::CFG_MAX_NUM, 1);
		run_phase(50, 0);

		// Text limit lowered in the middle of an open word.
		write_reg(rutf_pkg::CFG_MAX_TEXT, 100000);
		write_reg(rutf_pkg::CFG_MAX_WORD, 5);
		write_reg(rutf_pkg::CFG_MAX_NUM, 2);
		send_byte(8'hD0, 0); send_byte(8'hB4, 0);
		send_byte(8'hD0, 0); send_byte(8'hB0, 0);
		send_byte(8'hD0, 0);
		drain();
		write_reg(rutf_pkg::CFG_MAX_TEXT, 2);
		send_byte(8'hB5, 0); send_byte("x", 0); send_byte(" ", 1);
		drain();

		// A text limit of zero ignores everything.
		write_reg(rutf_pkg::CFG_MAX_TEXT, 0);
		run_phase(20, 0);

		// Back to the defaults, with no idling on either side.
		write_reg(rutf_pkg::CFG_MAX_TEXT, rutf_pkg::MAX_TEXT_RST);
		write_reg(rutf_pkg::CFG_MAX_WORD, rutf_pkg::MAX_WORD_RST);
		write_reg(rutf_pkg::CFG_MAX_NUM, rutf_pkg::MAX_NUM_RST);
		calm = 1;
		run_phase(70, 0);
		repeat (20) @(posedge clk);

		if (errors == 0 && pending_words.size() == 0) begin
			$display("All tests passed");
		end else begin
			if (pending_words.size() != 0)
				$error("%0d token words never arrived", pending_words.size());
			$display("Some tests failed");
		end
		$finish;
	end

endmodule
